// ===== rtl/packed_rgba_palette_ramp_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PACKED_RGBA_PALETTE_RAMP_UNIT_DEFINES_SVH
`define PACKED_RGBA_PALETTE_RAMP_UNIT_DEFINES_SVH

// Antecedent holds in this cycle, consequent must hold in the same cycle.
`define PRU_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pru check failed: same-cycle implication");

// Antecedent holds in this cycle, consequent must hold in the next cycle.
`define PRU_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pru check failed: next-cycle implication");

`endif

// ===== rtl/pru_pkg.sv =====
package pru_pkg;

  localparam int IDX_W       = 6;
  localparam int COLOR_W     = 32;
  localparam int STOP_W      = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int S_TDATA_W   = 80;
  localparam int M_TDATA_W   = 40;
  localparam int CHANNELS    = 4;
  localparam int CH_CNT_W    = 3;
  localparam int DIV_NUM_W   = 12;
  localparam int DIV_DEN_W   = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 1'b1;

  localparam logic [IDX_W-1:0]  LAST_INDEX_RST = 6'd63;
  localparam logic [STOP_W-1:0] STOP_COUNT_RST = 7'd2;
  localparam logic [STOP_W-1:0] MIN_STOPS      = 7'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_A,
    ST_DIV_B,
    ST_SETUP,
    ST_CH_START,
    ST_DIV_CH,
    ST_EMIT
  } pru_state_t;

  typedef enum logic [1:0] {
    OP_IDX_A,
    OP_IDX_B,
    OP_CHAN
  } pru_div_op_t;

  typedef struct packed {
    logic        load;
    logic        stop_store;
    logic        div_start;
    pru_div_op_t div_op;
    logic        latch_a;
    logic        latch_b;
    logic        setup;
    logic        latch_ch;
    logic        emit;
  } pru_cmd_t;

  typedef struct packed {
    logic mode;
    logic first_stop;
    logic div_done;
    logic n_zero;
    logic ch_all;
    logic at_end;
    logic out_free;
  } pru_status_t;

endpackage

// ===== rtl/packed_rgba_palette_ramp_unit.sv =====
// Palette ramp generator. Each input transaction yields a run of palette
// entries (index, color) that blend linearly between two RGBA colors; the
// last entry of a run carries tlast. tuser = 0 gives an explicit segment
// (start index/color, end index/color; swapped when given in reverse order).
// tuser = 1 feeds one gradient stop: the first stop of a run is stored and
// emits nothing, each later stop emits the segment from the previous stop,
// spread evenly over 0..last_index across stop_count stops. Writing either
// configuration register restarts the stop run. Entry colors leave with the
// bytes reversed (red in bits 7:0). One shared 12-step divider does all
// divisions. A segment is decoded and set up, runs four channel divisions,
// then emits one entry per cycle while the output is taken; a stalled
// output holds emission. A stop first runs two index divisions, a
// zero-length segment skips the channel divisions, and a first stop is
// only stored. Only one transaction is worked on at a time; the next is
// taken as soon as the final entry sits in the output register.
module packed_rgba_palette_ramp_unit
  import pru_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 64
)
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration: 0 last_index, 1 stop_count
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // start_index[5:0], start_color[37:6], end_index[43:38], end_color[75:44]
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // mode
  input  logic                  s_tuser,
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // entry_index[5:0], entry_color[37:6]
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic                  m_tlast
);

  pru_cmd_t    cmd;
  pru_status_t status;

  pru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pru_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== rtl/pru_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pru_div
  import pru_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo,
  output logic [DIV_DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(DIV_NUM_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  always_comb begin
    shifted = {rem, quo[DIV_NUM_W-1]};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/pru_datapath.sv =====
// Item registers, stop state, divider, per-channel accumulators, output register.
module pru_datapath
  import pru_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 64
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic                  m_tlast,
  input  pru_cmd_t              cmd,
  output pru_status_t           status
);

  localparam logic [IDX_W-1:0]  TOP_IDX   = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [STOP_W-1:0] MAX_STOPS = STOP_W'(PALETTE_ENTRIES);

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v);
    return (v > TOP_IDX) ? TOP_IDX : v;
  endfunction

  function automatic logic [COLOR_W-1:0] byte_rev(input logic [COLOR_W-1:0] c);
    return {c[7:0], c[15:8], c[23:16], c[31:24]};
  endfunction

  // configuration and run state
  logic [IDX_W-1:0]   last_index;
  logic [STOP_W-1:0]  stop_count;
  logic [STOP_W-1:0]  stops_seen;
  logic [COLOR_W-1:0] prev_color;

  // latched item
  logic               it_mode;
  logic [IDX_W-1:0]   it_si;
  logic [COLOR_W-1:0] it_sc;
  logic [IDX_W-1:0]   it_ei;
  logic [COLOR_W-1:0] it_ec;

  // segment
  logic [IDX_W-1:0]   a_idx;
  logic [IDX_W-1:0]   b_idx;
  logic [IDX_W-1:0]   seg_i0;
  logic [IDX_W-1:0]   seg_i1;
  logic [COLOR_W-1:0] seg_c0;
  logic [COLOR_W-1:0] seg_c1;
  logic [IDX_W-1:0]   n;
  logic [IDX_W-1:0]   k;
  logic [CH_CNT_W-1:0] ch;

  // per-channel step terms and accumulators
  logic [7:0] dq   [CHANNELS];
  logic [5:0] dr   [CHANNELS];
  logic [7:0] acc  [CHANNELS];
  logic [5:0] racc [CHANNELS];

  logic [7:0] c0b      [CHANNELS];
  logic [7:0] c1b      [CHANNELS];
  logic [7:0] dmag     [CHANNELS];
  logic       dneg     [CHANNELS];
  logic [7:0] init_b   [CHANNELS];
  logic [7:0] acc_next [CHANNELS];
  logic [5:0] racc_next[CHANNELS];

  logic [STOP_W-1:0]    s_eff;
  logic [IDX_W-1:0]     c_eff;
  logic [IDX_W-1:0]     i_cur;
  logic                 first_stop;
  logic [DIV_NUM_W-1:0] prod_a;
  logic [DIV_NUM_W-1:0] prod_b;

  logic [IDX_W-1:0]   set_i0;
  logic [IDX_W-1:0]   set_i1;
  logic [COLOR_W-1:0] set_c0;
  logic [COLOR_W-1:0] set_c1;
  logic [IDX_W-1:0]   cl_si;
  logic [IDX_W-1:0]   cl_ei;

  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_DEN_W-1:0] div_rem;

  logic [1:0] ch_sel;

  logic               out_valid;
  logic [IDX_W-1:0]   out_index;
  logic [COLOR_W-1:0] out_color;
  logic               out_last;
  logic               out_free;

  assign ch_sel = ch[1:0];
  assign n      = seg_i1 - seg_i0;

  // stop run arithmetic
  always_comb begin
    priority if (stop_count < MIN_STOPS) begin
      s_eff = MIN_STOPS;
    end else if (stop_count > MAX_STOPS) begin
      s_eff = MAX_STOPS;
    end else begin
      s_eff = stop_count;
    end
    c_eff      = clamp_idx(last_index);
    first_stop = (stops_seen == '0) || (stops_seen >= s_eff);
    i_cur      = stops_seen[IDX_W-1:0] - 1'b1;
    prod_a     = {6'd0, i_cur} * {6'd0, c_eff};
    prod_b     = {6'd0, IDX_W'(i_cur + 1'b1)} * {6'd0, c_eff};
  end

  // segment endpoints at setup
  always_comb begin
    cl_si = clamp_idx(it_si);
    cl_ei = clamp_idx(it_ei);
    if (it_mode) begin
      set_i0 = a_idx;
      set_i1 = b_idx;
      set_c0 = prev_color;
      set_c1 = it_ec;
    end else if (cl_si > cl_ei) begin
      set_i0 = cl_ei;
      set_i1 = cl_si;
      set_c0 = it_ec;
      set_c1 = it_sc;
    end else begin
      set_i0 = cl_si;
      set_i1 = cl_ei;
      set_c0 = it_sc;
      set_c1 = it_ec;
    end
  end

  // channel lanes: 0 red, 1 green, 2 blue, 3 alpha
  always_comb begin
    logic [8:0] d;
    logic [8:0] dn;
    logic [6:0] sum;
    logic       wrap;
    for (int j = 0; j < CHANNELS; j++) begin
      c0b[j]    = seg_c0[8*(3-j) +: 8];
      c1b[j]    = seg_c1[8*(3-j) +: 8];
      init_b[j] = set_c0[8*(3-j) +: 8];
      d         = {1'b0, c1b[j]} - {1'b0, c0b[j]};
      dn        = 9'd0 - d;
      dneg[j]   = d[8];
      dmag[j]   = d[8] ? dn[7:0] : d[7:0];
      sum       = {1'b0, racc[j]} + {1'b0, dr[j]};
      wrap      = sum >= {1'b0, n};
      racc_next[j] = wrap ? 6'(sum - {1'b0, n}) : sum[5:0];
      acc_next[j]  = acc[j] + dq[j] + {7'd0, wrap};
    end
  end

  always_comb begin
    unique case (cmd.div_op)
      OP_IDX_A: begin
        div_num = prod_a;
        div_den = DIV_DEN_W'(s_eff - 1'b1);
      end
      OP_IDX_B: begin
        div_num = prod_b;
        div_den = DIV_DEN_W'(s_eff - 1'b1);
      end
      OP_CHAN: begin
        div_num = {4'd0, dmag[ch_sel]};
        div_den = n;
      end
      default: begin
        div_num = prod_a;
        div_den = n;
      end
    endcase
  end

  pru_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // configuration and stop state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= LAST_INDEX_RST;
      stop_count <= STOP_COUNT_RST;
      stops_seen <= '0;
      prev_color <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LAST_INDEX: last_index <= cfg_data[IDX_W-1:0];
          REG_STOP_COUNT: stop_count <= cfg_data;
          default: ;
        endcase
        stops_seen <= '0;
      end else if (cmd.stop_store) begin
        prev_color <= it_ec;
        stops_seen <= STOP_W'(1);
      end else if (cmd.setup && it_mode) begin
        prev_color <= it_ec;
        stops_seen <= (STOP_W'(stops_seen + 1'b1) >= s_eff) ? '0 :
                      STOP_W'(stops_seen + 1'b1);
      end
    end
  end

  // item and segment registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_mode <= s_tuser;
      it_si   <= s_tdata[5:0];
      it_sc   <= s_tdata[37:6];
      it_ei   <= s_tdata[43:38];
      it_ec   <= s_tdata[75:44];
    end
    if (cmd.latch_a) begin
      a_idx <= clamp_idx(div_quo[IDX_W-1:0]);
    end
    if (cmd.latch_b) begin
      b_idx <= clamp_idx(div_quo[IDX_W-1:0]);
    end
    if (cmd.setup) begin
      seg_i0 <= set_i0;
      seg_i1 <= set_i1;
      seg_c0 <= set_c0;
      seg_c1 <= set_c1;
      k      <= '0;
      ch     <= '0;
      for (int j = 0; j < CHANNELS; j++) begin
        acc[j]  <= init_b[j];
        racc[j] <= '0;
      end
    end else if (cmd.latch_ch) begin
      ch <= ch + 1'b1;
      if (dneg[ch_sel] && (div_rem != '0)) begin
        dq[ch_sel] <= ~div_quo[7:0];
        dr[ch_sel] <= n - div_rem;
      end else if (dneg[ch_sel]) begin
        dq[ch_sel] <= 8'd0 - div_quo[7:0];
        dr[ch_sel] <= '0;
      end else begin
        dq[ch_sel] <= div_quo[7:0];
        dr[ch_sel] <= div_rem;
      end
    end else if (cmd.emit) begin
      k <= k + 1'b1;
      for (int j = 0; j < CHANNELS; j++) begin
        acc[j]  <= acc_next[j];
        racc[j] <= racc_next[j];
      end
    end
  end

  // output register
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (k == n) begin
        out_index <= seg_i1;
        out_color <= byte_rev(seg_c1);
        out_last  <= 1'b1;
      end else begin
        out_index <= seg_i0 + k;
        out_color <= {acc[3], acc[2], acc[1], acc[0]};
        out_last  <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_color, out_index};
  assign m_tlast  = out_last;

  always_comb begin
    status.mode       = it_mode;
    status.first_stop = first_stop;
    status.div_done   = div_done;
    status.n_zero     = (n == '0);
    status.ch_all     = ch[2];
    status.at_end     = (k == n);
    status.out_free   = out_free;
  end

endmodule

// ===== rtl/pru_ctrl.sv =====
// Sequencer: decode, index divisions, channel divisions, entry emission.
module pru_ctrl
  import pru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  pru_status_t status,
  output pru_cmd_t    cmd
);

  pru_state_t state;
  pru_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!status.mode) begin
          state_next = ST_SETUP;
        end else if (status.first_stop) begin
          cmd.stop_store = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_IDX_A;
          state_next    = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        if (status.div_done) begin
          cmd.latch_a   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_IDX_B;
          state_next    = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        if (status.div_done) begin
          cmd.latch_b = 1'b1;
          state_next  = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_CH_START;
      end
      ST_CH_START: begin
        if (status.n_zero || status.ch_all) begin
          state_next = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_op    = OP_CHAN;
          state_next    = ST_DIV_CH;
        end
      end
      ST_DIV_CH: begin
        cmd.div_op = OP_CHAN;
        if (status.div_done) begin
          cmd.latch_ch = 1'b1;
          state_next   = ST_CH_START;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.at_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pru_checker.sv =====
`include "packed_rgba_palette_ramp_unit_defines.svh"

// Port-level checks for the palette ramp unit.
module pru_checker
  import pru_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast
);

  logic             in_run;
  logic [IDX_W-1:0] prev_idx;
  logic [M_TDATA_W:0] out_word;
  logic [IDX_W-1:0]   next_idx;

  assign out_word = {m_tlast, m_tdata};
  assign next_idx = IDX_W'(prev_idx + 1'b1);

  // tracks whether the last taken entry left a run open
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      in_run <= !m_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      prev_idx <= m_tdata[IDX_W-1:0];
    end
  end

  // stalled output holds
  `PRU_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

  // output register empty right after reset
  `PRU_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !m_tvalid)

  // entries within a run walk up one index at a time
  `PRU_ASSERT_NOW(a_run_step, clk, rst, m_tvalid && in_run, m_tdata[IDX_W-1:0] == next_idx)

  // a new item is only taken once the final entry of the run is out
  `PRU_ASSERT_NOW(a_accept_at_end, clk, rst, s_tready && m_tvalid, m_tlast)

endmodule

bind packed_rgba_palette_ramp_unit pru_checker u_pru_checker (.*);
